FILE: rtl/dpc_pkg.sv
`default_nettype none

package dpc_pkg;

	// Field widths fixed by the item format.
	localparam int MODE_W = 2;
	localparam int DIST_W = 8;
	localparam int TIME_W = 32;
	localparam int STATUS_W = 4;
	localparam int TOL_W = 6;
	localparam int HOLD_W = 16;
	localparam int CAL_SUM_W = 12;
	localparam int CAL_CNT_W = 4;

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 1'b1;
	localparam logic [TOL_W-1:0] TOL_RESET = 6'd10;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd5000;

	// Calibration sample count and the divider length.
	localparam int CAL_SAMPLES_DEF = 10;
	localparam int DIV_STEPS = CAL_SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Mode codes of an input beat.
	localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CAL_START = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CAL_SAMPLE = 2'd2;

	// Distance constants.
	localparam logic [DIST_W-1:0] NO_ECHO_CM = 8'd250;
	localparam logic [DIST_W-1:0] IDEAL_MIN = 8'd40;
	localparam logic [DIST_W-1:0] IDEAL_LIMIT = 8'd70;
	localparam logic [DIST_W-1:0] FAR_MARGIN = 8'd10;
	localparam logic [DIST_W-1:0] AWAY_MARGIN = 8'd40;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_ERROR = 4'd0,
		STATUS_RANGE = 4'd1,
		STATUS_GOOD = 4'd2,
		STATUS_WARNING = 4'd3,
		STATUS_DANGER = 4'd4,
		STATUS_STANDBY = 4'd5,
		STATUS_NONE = 4'd6,
		STATUS_CALIBRATING = 4'd7,
		STATUS_CALIBRATED = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_GOOD,
		ST_FAR,
		ST_ELAPSED,
		ST_HOLD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [TOL_W-1:0] tolerance_cm;
		logic [HOLD_W-1:0] hold_time_ms;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DIST_W-1:0] distance_cm;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		status_t status;
		logic [DIST_W-1:0] reported_distance;
		logic [DIST_W-1:0] ideal_distance;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/dpc_sample_if.sv
`default_nettype none

interface dpc_sample_if;
	logic valid;
	logic ready;
	logic [dpc_pkg::MODE_W-1:0] mode;
	logic [dpc_pkg::DIST_W-1:0] distance_cm;
	logic [dpc_pkg::TIME_W-1:0] now_ms;

	modport source (output valid, output mode, output distance_cm, output now_ms,
		input ready);
	modport sink (input valid, input mode, input distance_cm, input now_ms,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/dpc_result_if.sv
`default_nettype none

interface dpc_result_if;
	logic valid;
	logic ready;
	logic [dpc_pkg::STATUS_W-1:0] status;
	logic [dpc_pkg::DIST_W-1:0] reported_distance;
	logic [dpc_pkg::DIST_W-1:0] ideal_distance;

	modport source (output valid, output status, output reported_distance,
		output ideal_distance, input ready);
	modport sink (input valid, input status, input reported_distance,
		input ideal_distance, output ready);
endinterface

`default_nettype wire

FILE: rtl/distance_posture_classifier.sv
`default_nettype none

// Channel   Dir  Beat carries
// sample    in   mode, distance_cm, now_ms
// result    out  status, reported_distance, ideal_distance
// wr_*      in   register index and data, no handshake
//
// One item at a time through a sequencer around a single 32-bit subtractor.
// A measure against a usable ideal runs the band compares, then for a reading that is
// not good the elapsed time and hold compare; the last calibration sample with any valid
// reading runs the 12-step divider. Every other item goes straight to its result. Reset
// clears the ideal, timer and calibration state. A stalled result waits in the output
// register while the next sample is taken.
module distance_posture_classifier #(
	parameter int CAL_SAMPLES = dpc_pkg::CAL_SAMPLES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	dpc_sample_if.sink                            sample,
	dpc_result_if.source                          result,
	input  wire logic                             wr_en,
	input  wire logic [dpc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [dpc_pkg::CFG_DATA_W-1:0]   wr_data
);

	dpc_pkg::cfg_t    cfg_q;
	dpc_pkg::sample_t in_beat;
	dpc_pkg::result_t res, out_q;
	logic             res_valid;
	logic             res_ready;
	logic             out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance_cm <= dpc_pkg::TOL_RESET;
			cfg_q.hold_time_ms <= dpc_pkg::HOLD_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				dpc_pkg::CFG_TOLERANCE: cfg_q.tolerance_cm <= wr_data[dpc_pkg::TOL_W-1:0];
				dpc_pkg::CFG_HOLD: cfg_q.hold_time_ms <= wr_data[dpc_pkg::HOLD_W-1:0];
			endcase
		end
	end

	assign in_beat.mode = sample.mode;
	assign in_beat.distance_cm = sample.distance_cm;
	assign in_beat.now_ms = sample.now_ms;

	dpc_engine #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.in_beat   (in_beat),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: takes a new result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.status = out_q.status;
	assign result.reported_distance = out_q.reported_distance;
	assign result.ideal_distance = out_q.ideal_distance;

endmodule

`default_nettype wire

FILE: rtl/dpc_alu.sv
`default_nettype none

// Shared subtractor: the band and hold compares, the elapsed time and each divide step use it.
module dpc_alu (
	input  wire logic [dpc_pkg::TIME_W-1:0] a,
	input  wire logic [dpc_pkg::TIME_W-1:0] b,
	output logic [dpc_pkg::TIME_W-1:0]      diff,
	output logic                            lt
);

	logic [dpc_pkg::TIME_W:0] full;

	// The borrow out of the top bit tells a < b for unsigned operands.
	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[dpc_pkg::TIME_W-1:0];
	assign lt = full[dpc_pkg::TIME_W];

endmodule

`default_nettype wire

FILE: rtl/dpc_engine.sv
`default_nettype none

module dpc_engine #(
	parameter int CAL_SAMPLES = dpc_pkg::CAL_SAMPLES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire dpc_pkg::sample_t  in_beat,
	input  wire dpc_pkg::cfg_t     cfg,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output dpc_pkg::result_t       res
);

	localparam int DW = dpc_pkg::DIST_W;
	localparam int TW = dpc_pkg::TIME_W;
	localparam int CW = dpc_pkg::CAL_CNT_W;
	localparam int SW = dpc_pkg::CAL_SUM_W;

	dpc_pkg::state_t state_q, state_d;

	logic [DW-1:0] dist_q;
	logic [TW-1:0] now_q;
	logic [TW-1:0] elapsed_q;
	logic          away_q;
	dpc_pkg::status_t status_q;
	logic [DW-1:0] rep_q;
	logic [DW-1:0] ideal_q;
	logic          timer_running_q;
	logic [TW-1:0] timer_start_q;
	logic [SW-1:0] cal_sum_q;
	logic [CW-1:0] cal_valid_q;
	logic [CW-1:0] cal_seen_q;
	logic          calibrating_q;
	logic [CW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic [dpc_pkg::DIV_CNT_W-1:0] cnt_q;

	logic          accept;
	logic [DW-1:0] dist_eff;
	logic          ideal_bad;
	logic [SW-1:0] sum_new;
	logic [CW-1:0] valid_new;
	logic [CW-1:0] seen_new;
	logic          cal_last;
	logic [DW:0]   near_sum;
	logic [DW:0]   band_sum;
	logic [CW:0]   trial;
	logic [TW-1:0] alu_a, alu_b, alu_diff;
	logic          alu_lt;

	assign accept = in_valid && in_ready;
	assign dist_eff = (in_beat.distance_cm == '0) ? dpc_pkg::NO_ECHO_CM : in_beat.distance_cm;
	assign ideal_bad = (ideal_q < dpc_pkg::IDEAL_MIN) || (ideal_q >= dpc_pkg::IDEAL_LIMIT);

	// Calibration accumulators as they stand after this sample.
	assign sum_new = (in_beat.distance_cm != '0)
		? cal_sum_q + SW'(in_beat.distance_cm) : cal_sum_q;
	assign valid_new = (in_beat.distance_cm != '0) ? cal_valid_q + CW'(1) : cal_valid_q;
	assign seen_new = cal_seen_q + CW'(1);
	assign cal_last = (seen_new >= CW'(CAL_SAMPLES));

	// Band limits: reading plus tolerance against the ideal, and ideal plus tolerance
	// plus the far or away margin against the reading.
	assign near_sum = (DW+1)'(dist_q) + (DW+1)'(cfg.tolerance_cm);
	assign band_sum = (DW+1)'(ideal_q) + (DW+1)'(cfg.tolerance_cm)
		+ (DW+1)'((state_q == dpc_pkg::ST_FAR) ? dpc_pkg::AWAY_MARGIN : dpc_pkg::FAR_MARGIN);
	assign trial = {rem_q, quo_q[SW-1]};

	// Operand selection for the shared subtractor.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			dpc_pkg::ST_CLOSE: begin
				alu_a = TW'(near_sum);
				alu_b = TW'(ideal_q);
			end
			dpc_pkg::ST_GOOD, dpc_pkg::ST_FAR: begin
				alu_a = TW'(band_sum);
				alu_b = TW'(dist_q);
			end
			dpc_pkg::ST_ELAPSED: begin
				alu_a = now_q;
				alu_b = timer_running_q ? timer_start_q : now_q;
			end
			dpc_pkg::ST_HOLD: begin
				alu_a = TW'(cfg.hold_time_ms);
				alu_b = elapsed_q;
			end
			dpc_pkg::ST_DIV: begin
				alu_a = TW'(trial);
				alu_b = TW'(cal_valid_q);
			end
			dpc_pkg::ST_IDLE, dpc_pkg::ST_DONE: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	dpc_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.lt   (alu_lt)
	);

	// Sequencer: next state and handshake outputs.
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			dpc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = dpc_pkg::ST_DONE;
					if (in_beat.mode == dpc_pkg::MODE_MEASURE && ideal_q != '0 && !ideal_bad) begin
						state_d = dpc_pkg::ST_CLOSE;
					end else if (in_beat.mode == dpc_pkg::MODE_CAL_SAMPLE && calibrating_q
						&& cal_last && valid_new != '0) begin
						state_d = dpc_pkg::ST_DIV;
					end
				end
			end
			dpc_pkg::ST_CLOSE: begin
				state_d = alu_lt ? dpc_pkg::ST_ELAPSED : dpc_pkg::ST_GOOD;
			end
			dpc_pkg::ST_GOOD: begin
				state_d = alu_lt ? dpc_pkg::ST_FAR : dpc_pkg::ST_DONE;
			end
			dpc_pkg::ST_FAR: begin
				state_d = dpc_pkg::ST_ELAPSED;
			end
			dpc_pkg::ST_ELAPSED: begin
				state_d = dpc_pkg::ST_HOLD;
			end
			dpc_pkg::ST_HOLD: begin
				state_d = dpc_pkg::ST_DONE;
			end
			dpc_pkg::ST_DIV: begin
				if (cnt_q == dpc_pkg::DIV_CNT_W'(dpc_pkg::DIV_STEPS - 1)) begin
					state_d = dpc_pkg::ST_DONE;
				end
			end
			dpc_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = dpc_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Architectural state: ideal, hold timer and calibration accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ideal_q <= '0;
			timer_running_q <= 1'b0;
			timer_start_q <= '0;
			cal_sum_q <= '0;
			cal_valid_q <= '0;
			cal_seen_q <= '0;
			calibrating_q <= 1'b0;
		end else begin
			if (accept && in_beat.mode == dpc_pkg::MODE_CAL_START) begin
				cal_sum_q <= '0;
				cal_valid_q <= '0;
				cal_seen_q <= '0;
				calibrating_q <= 1'b1;
			end else if (accept && in_beat.mode == dpc_pkg::MODE_CAL_SAMPLE && calibrating_q) begin
				cal_sum_q <= sum_new;
				cal_valid_q <= valid_new;
				cal_seen_q <= seen_new;
				if (cal_last) begin
					calibrating_q <= 1'b0;
					if (valid_new == '0) begin
						ideal_q <= '0;
					end
				end
			end
			// A good reading, or standby after the hold, stops the timer.
			if (state_q == dpc_pkg::ST_GOOD && !alu_lt) begin
				timer_running_q <= 1'b0;
				timer_start_q <= '0;
			end else if (state_q == dpc_pkg::ST_ELAPSED && !timer_running_q) begin
				timer_running_q <= 1'b1;
				timer_start_q <= now_q;
			end else if (state_q == dpc_pkg::ST_HOLD && away_q && alu_lt) begin
				timer_running_q <= 1'b0;
				timer_start_q <= '0;
			end
			if (state_q == dpc_pkg::ST_DIV
				&& cnt_q == dpc_pkg::DIV_CNT_W'(dpc_pkg::DIV_STEPS - 1)) begin
				ideal_q <= {quo_q[DW-2:0], !alu_lt};
			end
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		unique case (state_q)
			dpc_pkg::ST_IDLE: begin
				dist_q <= dist_eff;
				now_q <= in_beat.now_ms;
				away_q <= 1'b0;
				rem_q <= '0;
				quo_q <= sum_new;
				cnt_q <= '0;
				unique case (in_beat.mode)
					dpc_pkg::MODE_MEASURE: begin
						if (ideal_q == '0) begin
							status_q <= dpc_pkg::STATUS_ERROR;
							rep_q <= '0;
						end else if (ideal_bad) begin
							status_q <= dpc_pkg::STATUS_RANGE;
							rep_q <= '0;
						end else begin
							status_q <= dpc_pkg::STATUS_NONE;
							rep_q <= dist_eff;
						end
					end
					dpc_pkg::MODE_CAL_START: begin
						status_q <= dpc_pkg::STATUS_CALIBRATING;
						rep_q <= '0;
					end
					dpc_pkg::MODE_CAL_SAMPLE: begin
						if (calibrating_q) begin
							rep_q <= in_beat.distance_cm;
							status_q <= cal_last ? dpc_pkg::STATUS_CALIBRATED
								: dpc_pkg::STATUS_CALIBRATING;
						end else begin
							rep_q <= '0;
							status_q <= dpc_pkg::STATUS_NONE;
						end
					end
					default: begin
						status_q <= dpc_pkg::STATUS_NONE;
						rep_q <= '0;
					end
				endcase
			end
			dpc_pkg::ST_GOOD: begin
				if (!alu_lt) begin
					status_q <= dpc_pkg::STATUS_GOOD;
				end
			end
			dpc_pkg::ST_FAR: begin
				away_q <= alu_lt;
			end
			dpc_pkg::ST_ELAPSED: begin
				elapsed_q <= alu_diff;
			end
			dpc_pkg::ST_HOLD: begin
				if (away_q) begin
					status_q <= alu_lt ? dpc_pkg::STATUS_STANDBY : dpc_pkg::STATUS_NONE;
				end else begin
					status_q <= alu_lt ? dpc_pkg::STATUS_DANGER : dpc_pkg::STATUS_WARNING;
				end
			end
			dpc_pkg::ST_DIV: begin
				// Restoring divide, one quotient bit a cycle.
				rem_q <= alu_lt ? trial[CW-1:0] : alu_diff[CW-1:0];
				quo_q <= {quo_q[SW-2:0], !alu_lt};
				cnt_q <= cnt_q + dpc_pkg::DIV_CNT_W'(1);
			end
			dpc_pkg::ST_CLOSE, dpc_pkg::ST_DONE: begin
				status_q <= status_q;
			end
		endcase
	end

	assign res.status = status_q;
	assign res.reported_distance = rep_q;
	assign res.ideal_distance = ideal_q;

endmodule

`default_nettype wire
